// File: sv/glos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line-of-sight package
// Item types, register indexes and the command and status groups shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
package glos_pkg;

	localparam int MAX_SIDE  = 64;
	localparam int COORD_W   = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;

	localparam logic [CFG_W-1:0] MAP_SIDE_RESET = 7'd64;

	typedef struct packed {
		logic               opcode;
		logic [COORD_W-1:0] tile_x;
		logic [COORD_W-1:0] tile_y;
		logic               tile_is_wall;
		logic [COORD_W-1:0] from_x;
		logic [COORD_W-1:0] from_y;
		logic [COORD_W-1:0] to_x;
		logic [COORD_W-1:0] to_y;
	} req_item_t;

	typedef struct packed {
		logic path_clear;
		logic out_of_range;
	} rsp_item_t;

	typedef struct packed {
		logic wr;
		logic load;
		logic step;
		logic out_load;
		logic out_clear;
		logic out_oor;
	} cmd_t;

	typedef struct packed {
		logic oor;
		logic wr_ok;
		logic at_end;
		logic rd_wall;
	} sts_t;

endpackage
`default_nettype wire

// File: sv/glos_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line-of-sight datapath
// Map size registers, the wall map memory, the line stepper and the result
// register.
// ----------------------------------------------------------------------------
module glos_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [glos_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [glos_pkg::CFG_W-1:0]     cfg_data,
	input  wire glos_pkg::req_item_t            req,
	input  wire glos_pkg::cmd_t                 cmd,
	output glos_pkg::sts_t                      sts,
	output glos_pkg::rsp_item_t                 rsp
);

	localparam int DEPTH = glos_pkg::MAX_SIDE * glos_pkg::MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = glos_pkg::COORD_W;
	localparam int RW    = CW + glos_pkg::CFG_W;
	localparam int SW    = RW + 1;
	localparam int EW    = CW + 3;

	logic [glos_pkg::CFG_W-1:0] map_width_q, map_height_q;
	logic [glos_pkg::CFG_W-1:0] w_eff, h_eff;

	logic [CW-1:0] cur_x_q, cur_y_q, to_x_q, to_y_q, adx_q, ady_q;
	logic          neg_x_q, neg_y_q, ymaj_q;
	logic signed [EW-1:0] err_q;

	logic [CW-1:0] ax, ay, major, minor, ld_adx, ld_ady;
	logic [RW-1:0] row;
	logic [SW-1:0] sum;
	logic [AW-1:0] addr;
	logic signed [EW-1:0] err_sum, err_next;
	logic signed [EW:0]   twice;
	logic                 minor_step;

	logic mem [DEPTH];
	logic rd_q;
	glos_pkg::rsp_item_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= glos_pkg::MAP_SIDE_RESET;
			map_height_q <= glos_pkg::MAP_SIDE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				glos_pkg::CFG_MAP_WIDTH:  map_width_q  <= cfg_data;
				glos_pkg::CFG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A register above the largest map side acts as that side.
	assign w_eff = (32'(map_width_q) > glos_pkg::MAX_SIDE) ?
		glos_pkg::CFG_W'(glos_pkg::MAX_SIDE) : map_width_q;
	assign h_eff = (32'(map_height_q) > glos_pkg::MAX_SIDE) ?
		glos_pkg::CFG_W'(glos_pkg::MAX_SIDE) : map_height_q;

	assign sts.oor = ({1'b0, req.from_x} >= w_eff) || ({1'b0, req.from_y} >= h_eff) ||
		({1'b0, req.to_x} >= w_eff) || ({1'b0, req.to_y} >= h_eff);
	assign sts.wr_ok = ({1'b0, req.tile_x} < w_eff) && ({1'b0, req.tile_y} < h_eff);
	assign sts.at_end = ymaj_q ? (cur_y_q == to_y_q) : (cur_x_q == to_x_q);
	assign sts.rd_wall = rd_q;

	// One address generator serves both map writes and walk reads.
	assign ax   = cmd.wr ? req.tile_x : cur_x_q;
	assign ay   = cmd.wr ? req.tile_y : cur_y_q;
	assign row  = RW'(ay) * RW'(w_eff);
	assign sum  = SW'(ax) + SW'(row);
	assign addr = AW'(sum);

	always_ff @(posedge clk) begin
		if (cmd.wr && sts.wr_ok) begin
			mem[addr] <= req.tile_is_wall;
		end
		if (cmd.step) begin
			rd_q <= mem[addr];
		end
	end

	assign ld_adx = (req.to_x < req.from_x) ? (req.from_x - req.to_x) : (req.to_x - req.from_x);
	assign ld_ady = (req.to_y < req.from_y) ? (req.from_y - req.to_y) : (req.to_y - req.from_y);

	// Error term of the line: the minor axis moves once twice the error
	// reaches the major distance.
	assign major      = ymaj_q ? ady_q : adx_q;
	assign minor      = ymaj_q ? adx_q : ady_q;
	assign err_sum    = err_q + $signed({3'b000, minor});
	assign twice      = {err_sum, 1'b0};
	assign minor_step = twice >= $signed({4'b0000, major});
	assign err_next   = minor_step ? (err_sum - $signed({3'b000, major})) : err_sum;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q <= req.from_x;
			cur_y_q <= req.from_y;
			to_x_q  <= req.to_x;
			to_y_q  <= req.to_y;
			neg_x_q <= req.to_x < req.from_x;
			neg_y_q <= req.to_y < req.from_y;
			adx_q   <= ld_adx;
			ady_q   <= ld_ady;
			ymaj_q  <= !(ld_adx > ld_ady);
			err_q   <= '0;
		end else if (cmd.step) begin
			err_q <= err_next;
			if (!ymaj_q || minor_step) begin
				cur_x_q <= neg_x_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
			end
			if (ymaj_q || minor_step) begin
				cur_y_q <= neg_y_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.path_clear   <= cmd.out_clear;
			rsp_q.out_of_range <= cmd.out_oor;
		end
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

// File: sv/glos_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line-of-sight controller
// Accepts items, sequences the walk one tile per cycle and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module glos_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           opcode,
	output logic                req_stall,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output glos_pkg::cmd_t      cmd,
	input  wire glos_pkg::sts_t sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_RESP
	} state_t;

	state_t state_q;
	logic   rd_pend_q, res_clear_q, res_oor_q, rsp_valid_q;
	logic   accept, wall_hit;

	assign req_stall = state_q != S_IDLE;
	assign accept    = req_valid && !req_stall;
	// The read issued last cycle found a wall.
	assign wall_hit  = rd_pend_q && sts.rd_wall;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.wr   = opcode == glos_pkg::OP_WRITE;
					cmd.load = opcode == glos_pkg::OP_QUERY;
				end
			end
			S_WALK: begin
				cmd.step = !wall_hit && !sts.at_end;
			end
			S_RESP: begin
				cmd.out_load  = !rsp_valid_q || !rsp_stall;
				cmd.out_clear = res_clear_q;
				cmd.out_oor   = res_oor_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_pend_q   <= 1'b0;
			res_clear_q <= 1'b0;
			res_oor_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one taken in the same cycle.
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && opcode == glos_pkg::OP_QUERY) begin
						rd_pend_q <= 1'b0;
						if (sts.oor) begin
							res_clear_q <= 1'b0;
							res_oor_q   <= 1'b1;
							state_q     <= S_RESP;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (wall_hit) begin
						res_clear_q <= 1'b0;
						res_oor_q   <= 1'b0;
						rd_pend_q   <= 1'b0;
						state_q     <= S_RESP;
					end else if (sts.at_end) begin
						res_clear_q <= 1'b1;
						res_oor_q   <= 1'b0;
						rd_pend_q   <= 1'b0;
						state_q     <= S_RESP;
					end else begin
						rd_pend_q <= 1'b1;
					end
				end
				S_RESP: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

// File: sv/grid_line_of_sight.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid line of sight
// Keeps a one-bit wall map of a tile grid and answers line-of-sight queries.
// ----------------------------------------------------------------------------
// A write item stores one tile's wall bit if the tile lies on the configured
// map and gives no result. A query item walks a Bresenham line from the start
// tile toward the end tile, reading one tile of the single-port wall map per
// cycle; the walk stops at the first wall. A query with an endpoint off the
// configured map answers out of range without a walk. The wall map holds no
// defined value after reset and must be written before it is queried. The
// user must write the map size registers only while the block is idle; the
// block itself does not enforce it.
module grid_line_of_sight (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire glos_pkg::req_item_t            req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output glos_pkg::rsp_item_t                 rsp,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [glos_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [glos_pkg::CFG_W-1:0]     cfg_data
);

	glos_pkg::cmd_t cmd;
	glos_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	glos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.opcode    (req.opcode),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	glos_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
